// File: src/whp_pkg.sv
// ----------------------------------------------------------------------------
// whp_pkg
// Shared widths, command codes and register indexes of the weighted
// histogram peak finder.
// ----------------------------------------------------------------------------
package whp_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned Z_W        = 24;
  localparam int unsigned WGT_W      = 24;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned BIDX_W     = 10;
  localparam int unsigned SCALE_FRAC = 16;
  localparam int unsigned PROD_W     = Z_W + SCALE_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_W      = 24;

  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILL     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SUPPRESS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_Z_LOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_HIGH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE = 2'd2;

  localparam logic [Z_W-1:0]     Z_LOW_RST     = 24'h800000;
  localparam logic [Z_W-1:0]     Z_HIGH_RST    = 24'h7FFFFF;
  localparam logic [SCALE_W-1:0] BIN_SCALE_RST = 24'h010000;

endpackage

// File: src/weighted_histogram_peak_finder.sv
// ----------------------------------------------------------------------------
// weighted_histogram_peak_finder
// Weighted z histogram with a list of filled bins and a peak search that
// prunes empty bins from the list.
//
//   channel | dir | handshake              | fields
//   --------+-----+------------------------+----------------------------------
//   in      | in  | in_valid_i/in_ready_o  | cmd, z_pos, weight, bin_index
//   out     | out | out_valid_o/out_ready_i| accepted, peak_found, peak_bin,
//           |     |                        | peak_value
//   cfg     | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// fill maps z, then reads the bin ram word and writes it back; it skips both
// when out of range or weight zero. suppress reads the bin ram word, then
// writes back a zero sum. find reads each list entry, then its bin, newest
// first, with a move step per pruned entry; an empty list goes straight to
// the result. clear zeroes one bin ram word per cycle; after reset the same
// sweep runs before the first word is taken. one command in flight; the next
// word is taken while a result waits in the output register
// ----------------------------------------------------------------------------
module weighted_histogram_peak_finder #(
  parameter int unsigned NUM_BINS = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic        [whp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [whp_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic        [whp_pkg::CMD_W-1:0]      cmd_i,
  input  logic signed [whp_pkg::Z_W-1:0]        z_pos_i,
  input  logic        [whp_pkg::WGT_W-1:0]      weight_i,
  input  logic        [whp_pkg::BIDX_W-1:0]     bin_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  accepted_o,
  output logic                                  peak_found_o,
  output logic        [whp_pkg::BIDX_W-1:0]     peak_bin_o,
  output logic        [whp_pkg::SUM_W-1:0]      peak_value_o
);

  import whp_pkg::*;

  localparam int unsigned BinW  = $clog2(NUM_BINS);
  localparam int unsigned CntW  = BinW + 1;
  localparam int unsigned WordW = SUM_W + 1;

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_MAP  = 4'd2;
  localparam logic [3:0] ST_BIN  = 4'd3;
  localparam logic [3:0] ST_UPD  = 4'd4;
  localparam logic [3:0] ST_FRL  = 4'd5;
  localparam logic [3:0] ST_FRS  = 4'd6;
  localparam logic [3:0] ST_FCK  = 4'd7;
  localparam logic [3:0] ST_FMV  = 4'd8;
  localparam logic [3:0] ST_FEND = 4'd9;
  localparam logic [3:0] ST_RES  = 4'd10;

  // configuration
  logic signed [Z_W-1:0]   z_low_q;
  logic signed [Z_W-1:0]   z_high_q;
  logic        [SCALE_W-1:0] bin_scale_q;

  // control
  logic [3:0]       state_q;
  logic [BinW-1:0]  sweep_q;
  logic             clr_res_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  last_q;
  logic [BinW-1:0]  ib_q;
  logic             out_valid_q;

  // command word
  logic [CMD_W-1:0]     cmd_q;
  logic signed [Z_W-1:0] z_q;
  logic [WGT_W-1:0]     w_q;
  logic [BinW-1:0]      upd_addr_q;

  // scan state and result
  logic [BinW-1:0]  fb_q;
  logic [SUM_W-1:0] maxv_q;
  logic [BinW-1:0]  maxb_q;
  logic             any_q;
  logic             res_acc_q;
  logic             res_found_q;
  logic [BinW-1:0]  res_bin_q;
  logic [SUM_W-1:0] res_val_q;

  logic              acc_q;
  logic              found_q;
  logic [BIDX_W-1:0] pbin_q;
  logic [SUM_W-1:0]  pval_q;

  // rams
  logic             sum_we, sum_re;
  logic [BinW-1:0]  sum_waddr, sum_raddr;
  logic [WordW-1:0] sum_wdata, sum_rdata;
  logic             lst_we, lst_re;
  logic [BinW-1:0]  lst_waddr, lst_raddr;
  logic [BinW-1:0]  lst_wdata, lst_rdata;

  logic             map_ok;
  logic [BinW-1:0]  map_bin;

  logic             in_fire;
  logic             sup_ok;
  logic [SUM_W-1:0] cur_sum;
  logic             cur_listed;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sat_sum;
  logic             append;
  logic [CntW-1:0]  last_dec;
  logic [CntW-1:0]  cnt_dec;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign sup_ok     = 32'(bin_index_i) < 32'(NUM_BINS);

  assign cur_sum    = sum_rdata[SUM_W-1:0];
  assign cur_listed = sum_rdata[SUM_W];
  assign sum_ext    = {1'b0, cur_sum} + (SUM_W + 1)'(w_q);
  assign sat_sum    = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign append     = !cur_listed && (count_q < CntW'(NUM_BINS));
  assign last_dec   = last_q - CntW'(1);
  assign cnt_dec    = count_q - CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_low_q     <= Z_LOW_RST;
      z_high_q    <= Z_HIGH_RST;
      bin_scale_q <= BIN_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_Z_LOW:     z_low_q     <= cfg_data_i;
        CFG_Z_HIGH:    z_high_q    <= cfg_data_i;
        CFG_BIN_SCALE: bin_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  whp_bin_map #(
    .NUM_BINS(NUM_BINS)
  ) u_bin_map (
    .clk_i       (clk_i),
    .z_pos_i     (z_q),
    .z_low_i     (z_low_q),
    .z_high_i    (z_high_q),
    .bin_scale_i (bin_scale_q),
    .ok_o        (map_ok),
    .bin_o       (map_bin)
  );

  // bin ram: {listed, sum}
  whp_ram #(
    .Width(WordW),
    .Depth(NUM_BINS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  whp_ram #(
    .Width(BinW),
    .Depth(NUM_BINS)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (lst_we),
    .waddr_i (lst_waddr),
    .wdata_i (lst_wdata),
    .re_i    (lst_re),
    .raddr_i (lst_raddr),
    .rdata_o (lst_rdata)
  );

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = upd_addr_q;
    sum_wdata = '0;
    sum_re    = 1'b0;
    sum_raddr = lst_rdata;
    lst_we    = 1'b0;
    lst_waddr = ib_q;
    lst_wdata = lst_rdata;
    lst_re    = 1'b0;
    lst_raddr = ib_q;
    unique case (state_q)
      ST_INIT: begin
        sum_we    = 1'b1;
        sum_waddr = sweep_q;
      end
      ST_IDLE: begin
        if (in_fire && (cmd_i == CMD_SUPPRESS) && sup_ok) begin
          sum_re    = 1'b1;
          sum_raddr = BinW'(bin_index_i);
        end
      end
      ST_BIN: begin
        if (map_ok && (w_q != '0)) begin
          sum_re    = 1'b1;
          sum_raddr = map_bin;
        end
      end
      ST_UPD: begin
        sum_we = 1'b1;
        if (cmd_q == CMD_FILL) begin
          sum_wdata = {cur_listed | append, sat_sum};
          if (append) begin
            lst_we    = 1'b1;
            lst_waddr = count_q[BinW-1:0];
            lst_wdata = upd_addr_q;
          end
        end else begin
          sum_wdata = {cur_listed, {SUM_W{1'b0}}};
        end
      end
      ST_FRL: begin
        lst_re = 1'b1;
      end
      ST_FRS: begin
        sum_re    = 1'b1;
        sum_raddr = lst_rdata;
      end
      ST_FCK: begin
        if (!(cur_sum > maxv_q) && (cur_sum == '0)) begin
          // drop empty bin, fetch last live entry to fill the hole
          sum_we    = 1'b1;
          sum_waddr = fb_q;
          lst_re    = 1'b1;
          lst_raddr = last_dec[BinW-1:0];
        end
      end
      ST_FMV: begin
        lst_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      clr_res_q   <= 1'b0;
      count_q     <= '0;
      last_q      <= '0;
      ib_q        <= '0;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_CLEAR;
      z_q         <= '0;
      w_q         <= '0;
      upd_addr_q  <= '0;
      fb_q        <= '0;
      maxv_q      <= '0;
      maxb_q      <= '0;
      any_q       <= 1'b0;
      res_acc_q   <= 1'b0;
      res_found_q <= 1'b0;
      res_bin_q   <= '0;
      res_val_q   <= '0;
      acc_q       <= 1'b0;
      found_q     <= 1'b0;
      pbin_q      <= '0;
      pval_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_RES)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          if (sweep_q == BinW'(NUM_BINS - 1)) begin
            sweep_q <= '0;
            state_q <= clr_res_q ? ST_RES : ST_IDLE;
          end else begin
            sweep_q <= sweep_q + BinW'(1);
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            cmd_q       <= cmd_i;
            z_q         <= z_pos_i;
            w_q         <= weight_i;
            upd_addr_q  <= BinW'(bin_index_i);
            res_found_q <= 1'b0;
            res_bin_q   <= '0;
            res_val_q   <= '0;
            unique case (cmd_i)
              CMD_CLEAR: begin
                count_q   <= '0;
                clr_res_q <= 1'b1;
                res_acc_q <= 1'b1;
                state_q   <= ST_INIT;
              end
              CMD_FILL: begin
                res_acc_q <= 1'b0;
                state_q   <= ST_MAP;
              end
              CMD_FIND: begin
                maxv_q    <= '0;
                maxb_q    <= '0;
                any_q     <= 1'b0;
                last_q    <= count_q;
                ib_q      <= cnt_dec[BinW-1:0];
                res_acc_q <= (count_q == '0);
                if (count_q == '0) begin
                  state_q <= ST_RES;
                end else begin
                  state_q <= ST_FRL;
                end
              end
              default: begin
                res_acc_q <= 1'b0;
                state_q   <= sup_ok ? ST_UPD : ST_RES;
              end
            endcase
          end
        end
        ST_MAP: begin
          state_q <= ST_BIN;
        end
        ST_BIN: begin
          upd_addr_q <= map_bin;
          res_acc_q  <= map_ok;
          state_q    <= (map_ok && (w_q != '0)) ? ST_UPD : ST_RES;
        end
        ST_UPD: begin
          if ((cmd_q == CMD_FILL) && append) begin
            count_q <= count_q + CntW'(1);
          end
          res_acc_q <= 1'b1;
          state_q   <= ST_RES;
        end
        ST_FRL: begin
          state_q <= ST_FRS;
        end
        ST_FRS: begin
          fb_q    <= lst_rdata;
          state_q <= ST_FCK;
        end
        ST_FCK: begin
          if (cur_sum > maxv_q) begin
            maxv_q <= cur_sum;
            maxb_q <= fb_q;
            any_q  <= 1'b1;
          end
          if (!(cur_sum > maxv_q) && (cur_sum == '0)) begin
            last_q  <= last_dec;
            state_q <= ST_FMV;
          end else if (ib_q == '0) begin
            state_q <= ST_FEND;
          end else begin
            ib_q    <= ib_q - BinW'(1);
            state_q <= ST_FRL;
          end
        end
        ST_FMV: begin
          if (ib_q == '0) begin
            state_q <= ST_FEND;
          end else begin
            ib_q    <= ib_q - BinW'(1);
            state_q <= ST_FRL;
          end
        end
        ST_FEND: begin
          count_q     <= last_q;
          res_acc_q   <= 1'b1;
          res_found_q <= any_q;
          res_bin_q   <= maxb_q;
          res_val_q   <= maxv_q;
          state_q     <= ST_RES;
        end
        ST_RES: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            acc_q       <= res_acc_q;
            found_q     <= res_found_q;
            pbin_q      <= BIDX_W'(res_bin_q);
            pval_q      <= res_val_q;
            clr_res_q   <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = acc_q;
  assign peak_found_o = found_q;
  assign peak_bin_o   = pbin_q;
  assign peak_value_o = pval_q;

  // list never longer than the histogram
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(NUM_BINS))
    else $error("filled count beyond bin count");

  // one command at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("word taken while a command is in flight");

  // scan position stays below the live list end
  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FCK) |-> (last_q > {1'b0, ib_q}))
    else $error("scan index past live list end");

  // a found peak is always a positive accepted result
  a_peak_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && peak_found_o) |-> (accepted_o && (peak_value_o != '0)))
    else $error("peak reported with zero value");

endmodule

// File: src/whp_ram.sv
// ----------------------------------------------------------------------------
// whp_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module whp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/whp_bin_map.sv
// ----------------------------------------------------------------------------
// whp_bin_map
// Maps a z position to a histogram bin: range check and offset times
// reciprocal bin width, registered, then the bin bound check.
// ----------------------------------------------------------------------------
module whp_bin_map #(
  parameter int unsigned NUM_BINS = 1024,
  localparam int unsigned BinW = $clog2(NUM_BINS)
) (
  input  logic                             clk_i,
  input  logic signed [whp_pkg::Z_W-1:0]   z_pos_i,
  input  logic signed [whp_pkg::Z_W-1:0]   z_low_i,
  input  logic signed [whp_pkg::Z_W-1:0]   z_high_i,
  input  logic        [whp_pkg::SCALE_W-1:0] bin_scale_i,
  output logic                             ok_o,
  output logic        [BinW-1:0]           bin_o
);

  import whp_pkg::*;

  localparam int unsigned BinFieldW = PROD_W - SCALE_FRAC;

  logic signed [Z_W:0]   diff;
  logic [Z_W-1:0]        offset;
  logic                  in_range;
  logic [PROD_W-1:0]     prod_q;
  logic                  in_range_q;

  assign diff     = {z_pos_i[Z_W-1], z_pos_i} - {z_low_i[Z_W-1], z_low_i};
  assign offset   = diff[Z_W-1:0];
  assign in_range = (z_pos_i >= z_low_i) && (z_pos_i < z_high_i);

  always_ff @(posedge clk_i) begin
    in_range_q <= in_range;
    prod_q     <= PROD_W'(offset) * PROD_W'(bin_scale_i);
  end

  assign ok_o  = in_range_q && (prod_q[PROD_W-1:SCALE_FRAC] < BinFieldW'(NUM_BINS));
  assign bin_o = prod_q[SCALE_FRAC +: BinW];

endmodule

// File: tb/tb_weighted_histogram_peak_finder.sv
// ----------------------------------------------------------------------------
// tb_weighted_histogram_peak_finder
// Drives fill, find, suppress and clear words into the histogram block
// through a directed table and then randomized phases over several range
// and bin scale settings, with random idling on both channels. Every result
// word is compared field by field against an in-bench model of the bin sums
// and the list of filled bins, or against a fixed word for rows marked known.
// ----------------------------------------------------------------------------
module tb_weighted_histogram_peak_finder;
  timeunit 1ns;
  timeprecision 1ps;

  import whp_pkg::*;

  localparam int unsigned NUM_BINS = 1024;
  localparam logic signed [Z_W-1:0] Z0 = 24'sh800000;
  localparam logic [WGT_W-1:0] W_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic              accepted;
    logic              found;
    logic [BIDX_W-1:0] bin;
    logic [SUM_W-1:0]  value;
  } peak_word_t;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [Z_W-1:0]   z;
    logic [WGT_W-1:0]        w;
    logic [BIDX_W-1:0]       bidx;
    bit                      known;
    logic                    acc;
  } plan_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx = CFG_Z_LOW;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         cmd = CMD_CLEAR;
  logic signed [Z_W-1:0]    z_pos = '0;
  logic [WGT_W-1:0]         weight = '0;
  logic [BIDX_W-1:0]        bin_index = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     accepted;
  logic                     peak_found;
  logic [BIDX_W-1:0]        peak_bin;
  logic [SUM_W-1:0]         peak_value;

  // model of the histogram
  logic [SUM_W-1:0]         bin_sum [NUM_BINS];
  logic [BIDX_W-1:0]        fill_order [NUM_BINS];
  bit                       in_list [NUM_BINS];
  int                       fill_len;
  logic signed [Z_W-1:0]    lo_bound;
  logic signed [Z_W-1:0]    hi_bound;
  logic [SCALE_W-1:0]       scale_q16;

  peak_word_t               histo_results_q [$];
  plan_row_t                plan [$];
  int                       mismatches = 0;
  bit                       calm = 1'b0;

  weighted_histogram_peak_finder #(.NUM_BINS(NUM_BINS)) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd),
    .z_pos_i      (z_pos),
    .weight_i     (weight),
    .bin_index_i  (bin_index),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .accepted_o   (accepted),
    .peak_found_o (peak_found),
    .peak_bin_o   (peak_bin),
    .peak_value_o (peak_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic peak_word_t histo_step(logic [CMD_W-1:0] c, logic signed [Z_W-1:0] z,
                                            logic [WGT_W-1:0] w, logic [BIDX_W-1:0] bidx);
    peak_word_t       r;
    longint           zz, lo, hi, bin;
    logic [SUM_W:0]   total;
    int               i, idx, last;
    logic [SUM_W-1:0] v, best_v;
    logic [BIDX_W-1:0] b, best_b;
    bit               any;
    r = '0;
    case (c)
      CMD_CLEAR: begin
        for (i = 0; i < NUM_BINS; i++) begin
          bin_sum[i] = '0;
          in_list[i] = 1'b0;
        end
        fill_len = 0;
        r.accepted = 1'b1;
      end
      CMD_FILL: begin
        zz = z;
        lo = lo_bound;
        hi = hi_bound;
        if (zz >= lo && zz < hi) begin
          bin = ((zz - lo) * longint'(scale_q16)) >>> SCALE_FRAC;
          if (bin < NUM_BINS) begin
            r.accepted = 1'b1;
            if (w != '0) begin
              total = {1'b0, bin_sum[bin]} + w;
              if (!in_list[bin] && fill_len < NUM_BINS) begin
                fill_order[fill_len] = bin[BIDX_W-1:0];
                fill_len++;
                in_list[bin] = 1'b1;
              end
              bin_sum[bin] = total[SUM_W] ? '1 : total[SUM_W-1:0];
            end
          end
        end
      end
      CMD_FIND: begin
        idx = fill_len;
        last = fill_len;
        best_v = '0;
        best_b = '0;
        any = 1'b0;
        while (idx > 0) begin
          idx--;
          b = fill_order[idx];
          v = bin_sum[b];
          if (v > best_v) begin
            best_v = v;
            best_b = b;
            any = 1'b1;
          end else if (v == '0) begin
            in_list[b] = 1'b0;
            last--;
            fill_order[idx] = fill_order[last];
          end
        end
        fill_len = last;
        r.accepted = 1'b1;
        if (any) begin
          r.found = 1'b1;
          r.bin = best_b;
          r.value = best_v;
        end
      end
      default: begin
        if (bidx < NUM_BINS) begin
          bin_sum[bidx] = '0;
          r.accepted = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_word(logic [CMD_W-1:0] c, logic signed [Z_W-1:0] z,
                           logic [WGT_W-1:0] w, logic [BIDX_W-1:0] bidx,
                           bit known, logic acc);
    peak_word_t want;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    z_pos     <= z;
    weight    <= w;
    bin_index <= bidx;
    do @(posedge clk); while (!in_ready);
    want = histo_step(c, z, w, bidx);
    if (known) want = '{accepted: acc, found: 1'b0, bin: '0, value: '0};
    histo_results_q = {histo_results_q, want};
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (histo_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_range(logic signed [Z_W-1:0] lo, logic signed [Z_W-1:0] hi,
                           logic [SCALE_W-1:0] scale);
    drain();
    write_cfg(CFG_Z_LOW, lo);
    write_cfg(CFG_Z_HIGH, hi);
    write_cfg(CFG_BIN_SCALE, scale);
    lo_bound = lo;
    hi_bound = hi;
    scale_q16 = scale;
  endtask

  task automatic run_random(int n, int clr_pct, bit heavy, int calm_n);
    int                    k, roll, pick;
    longint                lo, hi, span, cap, zv;
    logic [CMD_W-1:0]      c;
    logic [WGT_W-1:0]      w;
    logic [BIDX_W-1:0]     bidx;
    for (k = 0; k < n; k++) begin
      calm = (k < calm_n);
      roll = $urandom_range(0, 99);
      if (!heavy && roll < clr_pct) c = CMD_CLEAR;
      else if (roll >= 88) c = CMD_FIND;
      else if (!heavy && roll >= 78) c = CMD_SUPPRESS;
      else c = CMD_FILL;

      lo = lo_bound;
      hi = hi_bound;
      span = hi - lo;
      if (scale_q16 != '0) begin
        cap = ((longint'(NUM_BINS) << SCALE_FRAC) + longint'(scale_q16) - 1)
              / longint'(scale_q16);
        if (cap < span) span = cap;
      end
      pick = $urandom_range(0, 99);
      if (span <= 0 || pick < 15) zv = $urandom;
      else if (pick < 22) begin
        case ($urandom_range(0, 5))
          0: zv = lo;
          1: zv = lo - 1;
          2: zv = hi - 1;
          3: zv = hi;
          4: zv = lo + span;
          default: zv = lo + span - 1;
        endcase
      end else zv = lo + longint'($urandom_range(0, span - 1));

      pick = $urandom_range(0, 99);
      if (heavy) w = (pick < 95) ? W_MAX : WGT_W'($urandom);
      else if (pick < 10) w = '0;
      else if (pick < 20) w = W_MAX;
      else if (pick < 60) w = WGT_W'($urandom_range(1, 255));
      else w = WGT_W'($urandom);

      if (fill_len > 0 && $urandom_range(0, 1) == 1)
        bidx = fill_order[$urandom_range(0, fill_len - 1)];
      else bidx = BIDX_W'($urandom);

      send_word(c, zv[Z_W-1:0], w, bidx, 1'b0, 1'b0);
    end
    calm = 1'b0;
  endtask

  function automatic plan_row_t row(logic [CMD_W-1:0] c, logic signed [Z_W-1:0] z,
                                    logic [WGT_W-1:0] w, logic [BIDX_W-1:0] bidx,
                                    bit known, logic acc);
    plan_row_t r;
    r.cmd = c;
    r.z = z;
    r.w = w;
    r.bidx = bidx;
    r.known = known;
    r.acc = acc;
    return r;
  endfunction

  task automatic add_row(logic [CMD_W-1:0] c, logic signed [Z_W-1:0] z,
                         logic [WGT_W-1:0] w, logic [BIDX_W-1:0] bidx,
                         bit known, logic acc);
    plan = {plan, row(c, z, w, bidx, known, acc)};
  endtask

  always @(negedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 17);

  always @(posedge clk) begin : result_check
    peak_word_t seen, want;
    if (rst_n && out_valid && out_ready) begin
      seen = {accepted, peak_found, peak_bin, peak_value};
      if (histo_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: word with nothing pending: acc %b found %b bin %0d value %0d",
                   $realtime, seen.accepted, seen.found, seen.bin, seen.value);
      end else begin
        want = histo_results_q.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: exp %b %b %0d %0d, got %b %b %0d %0d",
                     $realtime, want.accepted, want.found, want.bin, want.value,
                     seen.accepted, seen.found, seen.bin, seen.value);
        end
      end
    end
  end

  initial begin
    #(100_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int i;
    for (i = 0; i < NUM_BINS; i++) begin
      bin_sum[i] = '0;
      fill_order[i] = '0;
      in_list[i] = 1'b0;
    end
    fill_len = 0;
    lo_bound = Z_LOW_RST;
    hi_bound = Z_HIGH_RST;
    scale_q16 = BIN_SCALE_RST;

    // default range: bin is z minus the lowest z
    add_row(CMD_FIND,     '0,             '0,          '0,       1'b1, 1'b1);
    add_row(CMD_FILL,     Z0,             '0,          '0,       1'b1, 1'b1);
    add_row(CMD_FIND,     '0,             '0,          '0,       1'b1, 1'b1);
    add_row(CMD_FILL,     Z0 + 24'sd1023, W_MAX,       '0,       1'b1, 1'b1);
    add_row(CMD_FILL,     Z0 + 24'sd1024, 24'd5,       '0,       1'b1, 1'b0);
    add_row(CMD_FILL,     24'sh7FFFFF,    24'd1,       '0,       1'b1, 1'b0);
    add_row(CMD_FILL,     Z0 + 24'sd5,    24'd100,     '0,       1'b0, 1'b0);
    add_row(CMD_FILL,     Z0 + 24'sd7,    W_MAX,       '0,       1'b0, 1'b0);
    add_row(CMD_FIND,     '0,             '0,          '0,       1'b0, 1'b0);
    add_row(CMD_SUPPRESS, '0,             '0,          10'd7,    1'b1, 1'b1);
    add_row(CMD_FILL,     Z0 + 24'sd7,    24'd3,       '0,       1'b0, 1'b0);
    add_row(CMD_SUPPRESS, '0,             '0,          10'd5,    1'b1, 1'b1);
    add_row(CMD_FIND,     '0,             '0,          '0,       1'b0, 1'b0);
    add_row(CMD_SUPPRESS, '0,             '0,          10'd1023, 1'b1, 1'b1);
    add_row(CMD_SUPPRESS, '0,             '0,          10'd7,    1'b1, 1'b1);
    add_row(CMD_FIND,     '0,             '0,          '0,       1'b0, 1'b0);
    add_row(CMD_FIND,     '0,             '0,          '0,       1'b1, 1'b1);
    add_row(CMD_FILL,     Z0 + 24'sd2,    24'h5A5A5A,  '0,       1'b0, 1'b0);
    add_row(CMD_FILL,     Z0 + 24'sd2,    24'hA5A5A5,  '0,       1'b0, 1'b0);
    add_row(CMD_SUPPRESS, '0,             '0,          '0,       1'b1, 1'b1);
    add_row(CMD_FIND,     '0,             '0,          '0,       1'b0, 1'b0);
    add_row(CMD_CLEAR,    '0,             '0,          '0,       1'b1, 1'b1);
    add_row(CMD_FIND,     '0,             '0,          '0,       1'b1, 1'b1);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[j])
      send_word(plan[j].cmd, plan[j].z, plan[j].w, plan[j].bidx, plan[j].known, plan[j].acc);

    run_random(200, 3, 1'b0, 0);
    set_range(-24'sd262144, 24'sd262144, 24'd128);
    run_random(400, 2, 1'b0, 150);
    set_range(24'sd0, 24'sd100, 24'hFFFFFF);
    run_random(150, 3, 1'b0, 0);
    // every accepted fill lands in bin zero, sums run into saturation
    set_range(Z0, 24'sh7FFFFF, 24'd0);
    run_random(350, 0, 1'b1, 0);
    set_range(24'sh7FFFFF, Z0, 24'd4096);
    run_random(100, 3, 1'b0, 0);
    set_range(Z0, 24'sh7FFFFF, 24'd1);
    run_random(150, 3, 1'b0, 0);

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
src/whp_pkg.sv
src/whp_ram.sv
src/whp_bin_map.sv
src/weighted_histogram_peak_finder.sv
tb/tb_weighted_histogram_peak_finder.sv
